// ===== rtl/pfa_pkg.sv =====
`default_nettype none

package pfa_pkg;

    localparam int SIZE_W      = 16;
    localparam int PAGE_SIZE_W = 11;
    localparam int PAGES_W     = SIZE_W + 1;

    localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RESET = 11'd100;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_e;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_SIZE   = 3'd1,
        ST_NO_SPACE   = 3'd2,
        ST_LOADED     = 3'd3,
        ST_NOT_LOADED = 3'd4,
        ST_EMPTY      = 3'd5
    } status_e;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [3:0]        prog_id;
        logic [SIZE_W-1:0] request_size;
        logic [4:0]        frame_index;
    } pfa_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] frame_number;
        logic [3:0] owner_id;
        logic       occupied;
        logic [5:0] frames_count;
        logic       last;
    } pfa_out_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         prog_id;
        logic [PAGES_W-1:0] pages;
        logic               bad_size;
        logic [4:0]         frame_index;
    } pfa_op_t;

endpackage

`default_nettype wire

// ===== rtl/pfa_front.sv =====
`default_nettype none

module pfa_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire pfa_pkg::pfa_in_t                   s_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pfa_pkg::PAGE_SIZE_W-1:0]    cfg_data,
    output logic                                    q_valid,
    input  wire logic                               q_ready,
    output pfa_pkg::pfa_op_t                        q_data
);
    import pfa_pkg::*;

    localparam int CNT_W = $clog2(SIZE_W);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t                 state_reg, state_next;
    pfa_in_t                 item_reg;
    logic [PAGE_SIZE_W-1:0]  page_size_reg;
    logic [PAGE_SIZE_W-1:0]  rem_reg, rem_next;
    logic [SIZE_W-1:0]       quot_reg, quot_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [PAGE_SIZE_W-1:0]  divisor;
    logic [PAGE_SIZE_W:0]    trial;
    logic                    accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == F_IDLE);
    assign accept    = s_valid && s_ready;
    assign divisor   = (page_size_reg == '0) ? PAGE_SIZE_W'(1) : page_size_reg;
    assign trial     = {rem_reg, quot_reg[SIZE_W-1]};

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    rem_next  = '0;
                    quot_next = s_data.request_size;
                    cnt_next  = '0;
                    if (s_data.cmd == CMD_LOAD && s_data.request_size != '0) begin
                        state_next = F_DIV;
                    end else begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_DIV: begin
                // restoring division, one quotient bit per cycle
                if (trial >= {1'b0, divisor}) begin
                    rem_next  = PAGE_SIZE_W'(trial - {1'b0, divisor});
                    quot_next = {quot_reg[SIZE_W-2:0], 1'b1};
                end else begin
                    rem_next  = trial[PAGE_SIZE_W-1:0];
                    quot_next = {quot_reg[SIZE_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SIZE_W - 1)) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        q_valid             = (state_reg == F_PUSH);
        q_data.cmd          = item_reg.cmd;
        q_data.prog_id      = item_reg.prog_id;
        q_data.pages        = {1'b0, quot_reg} + PAGES_W'(rem_reg != '0);
        q_data.bad_size     = (item_reg.cmd == CMD_LOAD) && (item_reg.request_size == '0);
        q_data.frame_index  = item_reg.frame_index;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_IDLE;
            page_size_reg <= PAGE_SIZE_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                page_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
    end

endmodule

`default_nettype wire

// ===== rtl/pfa_queue.sv =====
`default_nettype none

module pfa_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pfa_pkg::pfa_op_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pfa_pkg::pfa_op_t       out_data
);
    import pfa_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pfa_op_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pfa_back.sv =====
`default_nettype none

module pfa_back #(
    parameter int NUM_FRAMES = 32,
    parameter int ID_WIDTH   = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire pfa_pkg::pfa_op_t  q_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output pfa_pkg::pfa_out_t      m_data
);
    import pfa_pkg::*;

    localparam int IW  = $clog2(NUM_FRAMES);
    localparam int CW  = $clog2(NUM_FRAMES + 1);
    localparam int NID = 1 << ID_WIDTH;

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_LOAD  = 5'b00010,
        B_REL   = 5'b00100,
        B_QUERY = 5'b01000,
        B_EMIT  = 5'b10000
    } bstate_t;

    bstate_t               state_reg, state_next;
    logic [NUM_FRAMES-1:0] used_reg, used_next;
    logic [NID-1:0]        present_reg, present_next;
    logic [CW-1:0]         free_cnt_reg, free_cnt_next;
    logic [CW-1:0]         remain_reg, remain_next;
    logic [CW-1:0]         pages_reg, pages_next;
    logic [CW-1:0]         k_reg, k_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [IW:0]           sidx_reg, sidx_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [IW-1:0]         chk_idx_reg, chk_idx_next;
    logic [ID_WIDTH-1:0]   id_reg, id_next;
    logic [IW-1:0]         qidx_reg, qidx_next;
    logic                  qin_reg, qin_next;
    pfa_out_t              res_reg, res_next;

    logic [ID_WIDTH-1:0]   owner_mem [NUM_FRAMES];
    logic [ID_WIDTH-1:0]   rd_data_reg;
    logic [IW-1:0]         mem_ra;
    logic                  mem_we;

    logic                  m_valid_reg;
    pfa_out_t              m_data_reg;

    logic [ID_WIDTH-1:0]   op_id;
    logic [IW-1:0]         op_idx;
    logic [IW-1:0]         cur;
    logic                  out_free;
    logic                  emit;
    pfa_out_t              emit_data;
    logic                  load_last;
    logic [CW-1:0]         load_remain;

    assign op_id       = ID_WIDTH'(q_data.prog_id);
    assign op_idx      = IW'(q_data.frame_index);
    assign cur         = sidx_reg[IW-1:0];
    assign out_free    = !m_valid_reg || m_ready;
    assign load_last   = ((k_reg + CW'(1)) == pages_reg);
    assign load_remain = free_cnt_reg - CW'(q_data.pages);

    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        present_next   = present_reg;
        free_cnt_next  = free_cnt_reg;
        remain_next    = remain_reg;
        pages_next     = pages_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        sidx_next      = sidx_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        id_next        = id_reg;
        qidx_next      = qidx_reg;
        qin_next       = qin_reg;
        res_next       = res_reg;
        q_ready        = 1'b0;
        emit           = 1'b0;
        emit_data      = res_reg;
        mem_we         = 1'b0;
        mem_ra         = cur;

        unique case (state_reg)
            B_IDLE: begin
                mem_ra = op_idx;
                if (q_valid) begin
                    q_ready       = 1'b1;
                    res_next      = '0;
                    res_next.last = 1'b1;
                    state_next    = B_EMIT;
                    case (q_data.cmd)
                        CMD_LOAD: begin
                            if (q_data.bad_size) begin
                                res_next.status = ST_BAD_SIZE;
                            end else if (present_reg[op_id]) begin
                                res_next.status = ST_LOADED;
                            end else if (q_data.pages > PAGES_W'(free_cnt_reg)) begin
                                res_next.status = ST_NO_SPACE;
                            end else begin
                                present_next[op_id] = 1'b1;
                                free_cnt_next       = load_remain;
                                remain_next         = load_remain;
                                pages_next          = CW'(q_data.pages);
                                k_next              = '0;
                                sidx_next           = '0;
                                id_next             = op_id;
                                state_next          = B_LOAD;
                            end
                        end
                        CMD_RELEASE: begin
                            if (!present_reg[op_id]) begin
                                res_next.status = ST_NOT_LOADED;
                            end else begin
                                present_next[op_id] = 1'b0;
                                id_next             = op_id;
                                sidx_next           = '0;
                                chk_valid_next      = 1'b0;
                                cnt_next            = '0;
                                state_next          = B_REL;
                            end
                        end
                        CMD_CLEAR: begin
                            if (present_reg == '0) begin
                                res_next.status = ST_EMPTY;
                            end else begin
                                // every used frame belongs to a loaded program
                                res_next.frames_count =
                                    6'(CW'(NUM_FRAMES) - free_cnt_reg);
                                used_next     = '0;
                                present_next  = '0;
                                free_cnt_next = CW'(NUM_FRAMES);
                            end
                        end
                        default: begin
                            res_next.frame_number = q_data.frame_index;
                            qin_next   = (int'(q_data.frame_index) < NUM_FRAMES);
                            qidx_next  = op_idx;
                            state_next = B_QUERY;
                        end
                    endcase
                end
            end
            B_LOAD: begin
                if (!used_reg[cur]) begin
                    emit                   = 1'b1;
                    emit_data              = '0;
                    emit_data.status       = ST_OK;
                    emit_data.frame_number = 5'(cur);
                    emit_data.frames_count = 6'(remain_reg);
                    emit_data.last         = load_last;
                    if (out_free) begin
                        used_next[cur] = 1'b1;
                        mem_we         = 1'b1;
                        k_next         = k_reg + CW'(1);
                        sidx_next      = sidx_reg + (IW+1)'(1);
                        if (load_last) begin
                            state_next = B_IDLE;
                        end
                    end
                end else begin
                    sidx_next = sidx_reg + (IW+1)'(1);
                end
            end
            B_REL: begin
                // owner read is issued in the cycle before the check
                if (sidx_reg < (IW+1)'(NUM_FRAMES)) begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = cur;
                    sidx_next      = sidx_reg + (IW+1)'(1);
                end else begin
                    chk_valid_next = 1'b0;
                end
                if (chk_valid_reg && used_reg[chk_idx_reg] && rd_data_reg == id_reg) begin
                    used_next[chk_idx_reg] = 1'b0;
                    cnt_next               = cnt_reg + CW'(1);
                    free_cnt_next          = free_cnt_reg + CW'(1);
                end
                if (sidx_reg == (IW+1)'(NUM_FRAMES) && !chk_valid_reg) begin
                    res_next              = '0;
                    res_next.status       = ST_OK;
                    res_next.frames_count = 6'(cnt_reg);
                    res_next.last         = 1'b1;
                    state_next            = B_EMIT;
                end
            end
            B_QUERY: begin
                res_next.occupied = qin_reg && used_reg[qidx_reg];
                res_next.owner_id = (qin_reg && used_reg[qidx_reg]) ? 4'(rd_data_reg) : '0;
                state_next        = B_EMIT;
            end
            B_EMIT: begin
                emit = 1'b1;
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            used_reg      <= '0;
            present_reg   <= '0;
            free_cnt_reg  <= CW'(NUM_FRAMES);
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            present_reg   <= present_next;
            free_cnt_reg  <= free_cnt_next;
            chk_valid_reg <= chk_valid_next;
            if (out_free) begin
                m_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        remain_reg  <= remain_next;
        pages_reg   <= pages_next;
        k_reg       <= k_next;
        cnt_reg     <= cnt_next;
        sidx_reg    <= sidx_next;
        chk_idx_reg <= chk_idx_next;
        id_reg      <= id_next;
        qidx_reg    <= qidx_next;
        qin_reg     <= qin_next;
        res_reg     <= res_next;
        if (out_free && emit) begin
            m_data_reg <= emit_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            owner_mem[cur] <= id_reg;
        end
        rd_data_reg <= owner_mem[mem_ra];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/page_frame_allocator_top.sv =====
`default_nettype none

// Page frame allocator over NUM_FRAMES frames with 2**ID_WIDTH program ids. Each transaction
// carries one command (load, release, release all, query). The front takes one command at a
// time: a load with a non-zero size goes through a bit-serial ceiling division of the size by
// page_size, every other command passes straight on. A two-entry queue sits between front and
// back. In the back, a load scans the frames from the lowest, one frame per cycle while the
// output is not stalled, and issues one result per frame given; a release sweeps all frames
// through the owner memory. Front and back overlap across consecutive commands. The user
// must write page_size over the cfg channel only while the block is idle; the block itself
// does not enforce this. Zero is taken as one.

module page_frame_allocator_top #(
    parameter int NUM_FRAMES = 32,
    parameter int ID_WIDTH   = 4
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire pfa_pkg::pfa_in_t                 s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output pfa_pkg::pfa_out_t                     m_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pfa_pkg::PAGE_SIZE_W-1:0]  cfg_data
);
    import pfa_pkg::*;

    logic    fq_valid, fq_ready;
    pfa_op_t fq_data;
    logic    qb_valid, qb_ready;
    pfa_op_t qb_data;

    pfa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    pfa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    pfa_back #(
        .NUM_FRAMES (NUM_FRAMES),
        .ID_WIDTH   (ID_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // front holds one command at a time
    a_front_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("front accepted back-to-back transactions");

    a_queue_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        fq_valid && fq_ready |=> qb_valid)
        else $error("queue lost a pushed command");

    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.last)
        else $error("rejection result not marked last");

    a_front_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        fq_valid && !fq_ready |=> fq_valid && $stable(fq_data))
        else $error("front dropped a command while the queue was full");

endmodule

`default_nettype wire
